[hw/rtl/proxy_arp_address_table_assert.svh]
// Assertion macros for the proxy ARP address table checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef PROXY_ARP_ADDRESS_TABLE_ASSERT_SVH
`define PROXY_ARP_ADDRESS_TABLE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define PAAT_CHK_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("proxy ARP table: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define PAAT_CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("proxy ARP table: next-cycle check failed");

`endif

[hw/rtl/paat_pkg.sv]
// Shared types and constants for the proxy ARP address table.
// No dependencies; used by the cell, the top level and the checker.
`default_nettype none

package paat_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam int CMD_W    = 2;
    localparam int IP_W     = 32;
    localparam int VLAN_W   = 12;
    localparam int MAC_W    = 48;
    localparam int STATUS_W = 2;
    localparam int USED_W   = 5;

    // Largest count the used_count field can carry.
    localparam logic [USED_W-1:0] USED_MAX = 5'd31;

    // Top nibble of an IPv4 multicast address.
    localparam logic [3:0] MCAST_IP_NIBBLE = 4'hE;
    // Group bit of the first MAC octet.
    localparam int MCAST_MAC_BIT = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_DELETE = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_MCAST     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_UPDATE,
        OP_FILL,
        OP_DELETE
    } commit_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_COMMIT
    } state_t;

    // Search token passed from cell to cell.
    typedef struct packed {
        logic             active;
        logic             hit_seen;
        logic             free_seen;
        logic [MAC_W-1:0] mac_found;
    } token_t;

    // Key, data and commit operation broadcast to every cell.
    typedef struct packed {
        commit_op_t        op;
        logic [IP_W-1:0]   ip;
        logic [VLAN_W-1:0] vlan;
        logic [MAC_W-1:0]  mac;
    } bcast_t;

endpackage

`default_nettype wire

[hw/rtl/paat_cell.sv]
// One table entry of the proxy ARP address table plus its token stage.
// Depends on paat_pkg.
`default_nettype none

module paat_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire paat_pkg::bcast_t bcast,
    input  wire paat_pkg::token_t token_in,
    output paat_pkg::token_t      token_out
);

    logic                          valid_reg, valid_next;
    logic [paat_pkg::IP_W-1:0]     ip_reg, ip_next;
    logic [paat_pkg::VLAN_W-1:0]   vlan_reg, vlan_next;
    logic [paat_pkg::MAC_W-1:0]    mac_reg, mac_next;
    logic                          hit_flag_reg, hit_flag_next;
    logic                          free_flag_reg, free_flag_next;
    paat_pkg::token_t              token_reg, token_next;

    logic match;
    logic hit_here;
    logic free_here;

    assign match     = valid_reg && (ip_reg == bcast.ip) && (vlan_reg == bcast.vlan);
    assign hit_here  = token_in.active && match && !token_in.hit_seen;
    assign free_here = token_in.active && !valid_reg && !token_in.free_seen;

    // Advance the token; claim the first hit and the first free slot.
    always_comb
    begin
        token_next.active    = token_in.active;
        token_next.hit_seen  = token_in.hit_seen || hit_here;
        token_next.free_seen = token_in.free_seen || free_here;
        token_next.mac_found = hit_here ? mac_reg : token_in.mac_found;

        hit_flag_next  = hit_flag_reg;
        free_flag_next = free_flag_reg;
        if (token_in.active)
        begin
            hit_flag_next  = hit_here;
            free_flag_next = free_here;
        end
    end

    // Apply the commit to this entry if it was the claimed one.
    always_comb
    begin
        valid_next = valid_reg;
        ip_next    = ip_reg;
        vlan_next  = vlan_reg;
        mac_next   = mac_reg;
        unique case (bcast.op)
            paat_pkg::OP_NONE:
            begin
            end
            paat_pkg::OP_UPDATE:
            begin
                if (hit_flag_reg)
                begin
                    mac_next = bcast.mac;
                end
            end
            paat_pkg::OP_FILL:
            begin
                if (free_flag_reg)
                begin
                    valid_next = 1'b1;
                    ip_next    = bcast.ip;
                    vlan_next  = bcast.vlan;
                    mac_next   = bcast.mac;
                end
            end
            paat_pkg::OP_DELETE:
            begin
                if (hit_flag_reg)
                begin
                    valid_next = 1'b0;
                    ip_next    = '0;
                    mac_next   = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            hit_flag_reg  <= 1'b0;
            free_flag_reg <= 1'b0;
            token_reg     <= '0;
        end
        else
        begin
            valid_reg     <= valid_next;
            hit_flag_reg  <= hit_flag_next;
            free_flag_reg <= free_flag_next;
            token_reg     <= token_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ip_reg   <= ip_next;
        vlan_reg <= vlan_next;
        mac_reg  <= mac_next;
    end

    assign token_out = token_reg;

endmodule

`default_nettype wire

[hw/rtl/proxy_arp_address_table.sv]
// Proxy ARP address table: a row of entry cells searched by a moving token.
// Depends on paat_pkg and paat_cell.
//
//  channel  | handshake            | fields
//  ---------+----------------------+--------------------------------------
//  request  | in_valid / in_stall  | command, ip_addr, vlan_id, mac_in
//  result   | out_valid / out_stall| status, mac_out, used_count
//
// Flow: a request is loaded, then the search token is launched and walks
//   the row of TABLE_DEPTH cells one cell per cycle, then the result is
//   committed. One request is in work at a time.
// Reset: all valid marks clear at once; the table is empty right after reset.
// Stalls: a finished result waits in the output register while the next
//   request is taken and searched; only its commit waits for the slot.
`default_nettype none

module proxy_arp_address_table #(
    parameter int TABLE_DEPTH = paat_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [paat_pkg::CMD_W-1:0]     command,
    input  wire logic [paat_pkg::IP_W-1:0]      ip_addr,
    input  wire logic [paat_pkg::VLAN_W-1:0]    vlan_id,
    input  wire logic [paat_pkg::MAC_W-1:0]     mac_in,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [paat_pkg::STATUS_W-1:0]       status,
    output logic [paat_pkg::MAC_W-1:0]          mac_out,
    output logic [paat_pkg::USED_W-1:0]         used_count
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int SAT_W = (CNT_W > paat_pkg::USED_W) ? CNT_W : paat_pkg::USED_W;

    paat_pkg::state_t                state_reg, state_next;
    logic                            launch_reg, launch_next;
    logic [paat_pkg::CMD_W-1:0]      cmd_reg;
    logic [paat_pkg::IP_W-1:0]       ip_reg;
    logic [paat_pkg::VLAN_W-1:0]     vlan_reg;
    logic [paat_pkg::MAC_W-1:0]      mac_reg;
    paat_pkg::token_t                tail_reg;
    logic [CNT_W-1:0]                used_reg, used_next;
    logic                            out_valid_reg, out_valid_next;
    paat_pkg::status_t               out_status_reg;
    logic [paat_pkg::MAC_W-1:0]      out_mac_reg;
    logic [paat_pkg::USED_W-1:0]     out_used_reg;

    paat_pkg::token_t                tok [0:TABLE_DEPTH];
    paat_pkg::bcast_t                bcast;

    logic                            accept;
    logic                            commit_go;
    logic                            is_mcast;
    paat_pkg::status_t               res_status;
    logic [paat_pkg::MAC_W-1:0]      res_mac;
    paat_pkg::commit_op_t            res_op;
    logic [SAT_W-1:0]                used_ext;
    logic [paat_pkg::USED_W-1:0]     used_sat;

    // ---------------------------------------------------------------
    // Cell row: the token enters cell 0 from launch_reg, in the cycle after the
    // request is accepted, so the key registers are stable while it walks.
    // ---------------------------------------------------------------
    assign tok[0] = '{active: launch_reg, hit_seen: 1'b0, free_seen: 1'b0,
                      mac_found: '0};

    generate
        for (genvar i = 0; i < TABLE_DEPTH; i++)
        begin : g_cell
            paat_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .bcast     (bcast),
                .token_in  (tok[i]),
                .token_out (tok[i+1])
            );
        end
    endgenerate

    // Broadcast the key all the time; the commit op only when it is taken.
    assign bcast.op   = commit_go ? res_op : paat_pkg::OP_NONE;
    assign bcast.ip   = ip_reg;
    assign bcast.vlan = vlan_reg;
    assign bcast.mac  = mac_reg;

    // ---------------------------------------------------------------
    // Control: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            paat_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = paat_pkg::S_WALK;
                end
            end
            paat_pkg::S_WALK:
            begin
                if (tok[TABLE_DEPTH].active)
                begin
                    state_next = paat_pkg::S_COMMIT;
                end
            end
            paat_pkg::S_COMMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = paat_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = paat_pkg::S_IDLE;
            end
        endcase
    end

    // Control: outputs of the state machine
    always_comb
    begin
        in_stall  = (state_reg != paat_pkg::S_IDLE);
        accept    = (state_reg == paat_pkg::S_IDLE) && in_valid;
        commit_go = (state_reg == paat_pkg::S_COMMIT) && (!out_valid_reg || !out_stall);
        launch_next = accept;
    end

    // ---------------------------------------------------------------
    // Decide the result from the token that left the last cell.
    // Multicast rejects come before any table action on an add.
    // ---------------------------------------------------------------
    assign is_mcast = mac_reg[paat_pkg::MCAST_MAC_BIT]
                   || (ip_reg[paat_pkg::IP_W-1 -: 4] == paat_pkg::MCAST_IP_NIBBLE);

    always_comb
    begin
        res_status = paat_pkg::ST_NOT_FOUND;
        res_mac    = '0;
        res_op     = paat_pkg::OP_NONE;
        used_next  = used_reg;
        unique case (cmd_reg)
            paat_pkg::CMD_LOOKUP:
            begin
                if (tail_reg.hit_seen)
                begin
                    res_status = paat_pkg::ST_OK;
                    res_mac    = tail_reg.mac_found;
                end
            end
            paat_pkg::CMD_ADD:
            begin
                priority if (is_mcast)
                begin
                    res_status = paat_pkg::ST_MCAST;
                end
                else if (tail_reg.hit_seen)
                begin
                    res_status = paat_pkg::ST_OK;
                    res_op     = paat_pkg::OP_UPDATE;
                end
                else if (tail_reg.free_seen)
                begin
                    res_status = paat_pkg::ST_OK;
                    res_op     = paat_pkg::OP_FILL;
                    used_next  = used_reg + CNT_W'(1);
                end
                else
                begin
                    res_status = paat_pkg::ST_FULL;
                end
            end
            paat_pkg::CMD_DELETE:
            begin
                if (tail_reg.hit_seen)
                begin
                    res_status = paat_pkg::ST_OK;
                    res_op     = paat_pkg::OP_DELETE;
                    used_next  = used_reg - CNT_W'(1);
                end
            end
            default:
            begin
                // unused command code: answer not found, touch nothing
            end
        endcase
    end

    // Saturate the count to the width of the result field.
    assign used_ext = SAT_W'(used_next);
    assign used_sat = (used_ext > SAT_W'(paat_pkg::USED_MAX)) ? paat_pkg::USED_MAX
                                                             : used_ext[paat_pkg::USED_W-1:0];

    // Output register: load on commit, drop once taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= paat_pkg::S_IDLE;
            launch_reg    <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
            if (commit_go)
            begin
                used_reg <= used_next;
            end
        end
    end

    // Hold the request while it is in work; capture the tail token.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            ip_reg   <= ip_addr;
            vlan_reg <= vlan_id;
            mac_reg  <= mac_in;
        end
        if (tok[TABLE_DEPTH].active)
        begin
            tail_reg <= tok[TABLE_DEPTH];
        end
        if (commit_go)
        begin
            out_status_reg <= res_status;
            out_mac_reg    <= res_mac;
            out_used_reg   <= used_sat;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign mac_out    = out_mac_reg;
    assign used_count = out_used_reg;

endmodule

`default_nettype wire

[hw/rtl/paat_checker.sv]
// Port-level checker for the proxy ARP address table, bound to the top level.
// Depends on paat_pkg and proxy_arp_address_table_assert.svh.
`default_nettype none

`include "proxy_arp_address_table_assert.svh"

module paat_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_stall,
    input wire logic                           out_valid,
    input wire logic                           out_stall,
    input wire logic [paat_pkg::STATUS_W-1:0]  status,
    input wire logic [paat_pkg::MAC_W-1:0]     mac_out
);

    // A taken request closes the request channel while it is in work.
    `PAAT_CHK_NEXT(a_one_in_work, in_valid && !in_stall, in_stall)

    // A result never appears right after its request was taken.
    `PAAT_CHK_NEXT(a_no_early_result, in_valid && !in_stall, !$rose(out_valid))

    // Only a successful lookup carries a MAC.
    `PAAT_CHK_NOW(a_mac_only_on_ok, out_valid && (status != paat_pkg::ST_OK), mac_out == '0)

    // A stalled result holds.
    `PAAT_CHK_NEXT(a_result_holds, out_valid && out_stall,
                   out_valid && $stable(status) && $stable(mac_out))

endmodule

bind proxy_arp_address_table paat_checker u_paat_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .mac_out   (mac_out)
);

`default_nettype wire
